FILE: sv/eed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eed_pkg
// Shared codes and character constants for the echo escape decoder.
// ----------------------------------------------------------------------------
package eed_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] FUNC_BYTE     = 2'd0;
  localparam logic [1:0] FUNC_BOUNDARY = 2'd1;
  localparam logic [1:0] FUNC_EOL      = 2'd2;

  // Decode state codes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_OCTAL  = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  // Characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  // One queued result: byte plus last-of-item mark
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } result_t;

endpackage

FILE: sv/echo_escape_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_escape_decoder_core
// Decodes a stream of echo arguments (bytes, boundaries, end of line) into
// output bytes, handling backslash escapes, octal values and the stop escape.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata           | tuser / tlast
//  ---------+-----------+-----------------+-------------------------------
//  s_axis   | in        | [7:0] byte_in   | tuser [1:0] func
//  m_axis   | out       | [7:0] out_byte  | tlast last_of_item
//  cfg      | in        | [0] suppress_nl | write enable, no read-back
//
//  An input transaction is decoded in the cycle it is accepted; its zero to
//  two results enter a four-entry result queue and appear on m_axis from the
//  next cycle on. One item per cycle is sustained while each item makes at
//  most one result and m_axis stays ready; the two results of an item leave
//  the queue one transaction each. Input ready is set purely by queue room
//  (two free slots), so s_axis stalls as soon as fewer than two queue slots
//  are free. Reset clears decode state, queue pointers, count and register.
//
module echo_escape_decoder_core
  import eed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,      // [0] suppress_newline
  // Input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // [7:0] byte_in
  input  logic [1:0] s_axis_tuser,     // [1:0] func
  // Output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,     // [7:0] out_byte
  output logic       m_axis_tlast      // last_of_item
);

  logic            suppress_nl_q;
  logic [1:0]      mode_q, mode_d;
  logic [1:0]      oct_cnt_q, oct_cnt_d;
  logic [7:0]      oct_val_q, oct_val_d;

  result_t         queue_q [QDepth];
  logic [QAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QAw:0]    count_q;

  logic            in_fire, out_fire;
  logic [1:0]      n_res;
  logic [7:0]      res0, res1;

  // Decode helpers
  logic [7:0]      oct_next;
  logic [1:0]      oct_cnt_inc;
  logic            is_digit;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Need room for the worst case of two results
  assign s_axis_tready = (count_q <= 3'(QDepth - 2));

  assign is_digit    = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_SEVEN);
  assign oct_next    = {oct_val_q[4:0], 3'b000} + {5'd0, s_axis_tdata[2:0]};
  assign oct_cnt_inc = oct_cnt_q + 2'd1;

  // --------------------------------------------------------------------------
  // Decode one item: results and next state
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0] owed;
    logic       has_owed;
    mode_d    = mode_q;
    oct_cnt_d = oct_cnt_q;
    oct_val_d = oct_val_q;
    n_res     = 2'd0;
    res0      = s_axis_tdata;
    res1      = s_axis_tdata;
    // What a pending escape or octal run still owes when it is cut short
    has_owed  = (mode_q == MODE_ESC) || (mode_q == MODE_OCTAL);
    owed      = (mode_q == MODE_ESC) ? CH_BSLASH : oct_val_q;

    unique case (s_axis_tuser)
      FUNC_BYTE: begin
        unique case (mode_q)
          MODE_NORMAL: begin
            if (s_axis_tdata == CH_BSLASH) begin
              mode_d = MODE_ESC;
            end else begin
              n_res = 2'd1;
            end
          end
          MODE_ESC: begin
            mode_d = MODE_NORMAL;
            n_res  = 2'd1;
            unique case (s_axis_tdata)
              CH_LC_A:   res0 = CH_BEL;
              CH_LC_B:   res0 = CH_BS;
              CH_LC_F:   res0 = CH_FF;
              CH_LC_N:   res0 = CH_NL;
              CH_LC_R:   res0 = CH_CR;
              CH_LC_T:   res0 = CH_TAB;
              CH_LC_V:   res0 = CH_VT;
              CH_BSLASH: res0 = CH_BSLASH;
              CH_LC_C: begin
                mode_d = MODE_STOP;
                n_res  = 2'd0;
              end
              CH_ZERO: begin
                mode_d    = MODE_OCTAL;
                oct_cnt_d = 2'd0;
                oct_val_d = 8'd0;
                n_res     = 2'd0;
              end
              default: begin
                // Unknown escape: backslash, then the byte itself
                res0  = CH_BSLASH;
                n_res = 2'd2;
              end
            endcase
          end
          MODE_OCTAL: begin
            if (is_digit) begin
              oct_val_d = oct_next;
              oct_cnt_d = oct_cnt_inc;
              if (oct_cnt_inc == 2'd3) begin
                res0      = oct_next;
                n_res     = 2'd1;
                mode_d    = MODE_NORMAL;
                oct_cnt_d = 2'd0;
                oct_val_d = 8'd0;
              end
            end else begin
              // Emit the value, then treat the byte as in normal mode
              res0      = oct_val_q;
              oct_cnt_d = 2'd0;
              oct_val_d = 8'd0;
              if (s_axis_tdata == CH_BSLASH) begin
                mode_d = MODE_ESC;
                n_res  = 2'd1;
              end else begin
                mode_d = MODE_NORMAL;
                n_res  = 2'd2;
              end
            end
          end
          default: begin
            // Stopped: drop everything
          end
        endcase
      end
      FUNC_BOUNDARY: begin
        if (mode_q != MODE_STOP) begin
          mode_d    = MODE_NORMAL;
          oct_cnt_d = 2'd0;
          oct_val_d = 8'd0;
          if (has_owed) begin
            res0  = owed;
            res1  = CH_SPACE;
            n_res = 2'd2;
          end else begin
            res0  = CH_SPACE;
            n_res = 2'd1;
          end
        end
      end
      FUNC_EOL: begin
        mode_d    = MODE_NORMAL;
        oct_cnt_d = 2'd0;
        oct_val_d = 8'd0;
        if (mode_q != MODE_STOP) begin
          res0 = has_owed ? owed : CH_NL;
          res1 = CH_NL;
          unique case ({has_owed, suppress_nl_q})
            2'b00:   n_res = 2'd1;
            2'b01:   n_res = 2'd0;
            2'b10:   n_res = 2'd2;
            default: n_res = 2'd1;
          endcase
        end
      end
      default: begin
        // Unused kind: no result, state held
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suppress_nl_q <= 1'b0;
      mode_q        <= MODE_NORMAL;
      oct_cnt_q     <= 2'd0;
      oct_val_q     <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        suppress_nl_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        mode_q    <= mode_d;
        oct_cnt_q <= oct_cnt_d;
        oct_val_q <= oct_val_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: push up to two per accepted item, pop one per transaction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QAw'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QAw'(1);
      end
      count_q <= count_q + (in_fire ? (QAw+1)'(n_res) : '0) - (QAw+1)'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= '{last: (n_res == 2'd1), data: res0};
    end
    if (in_fire && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + QAw'(1)] <= '{last: 1'b1, data: res1};
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = queue_q[rd_ptr_q].data;
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;

endmodule
